// ===== rtl/core/blup_pkg.sv =====
`timescale 1ns / 1ps
// blup_pkg: shared types, widths and register codes for the bilinear upscaler
// no dependencies
package blup_pkg;

  localparam int SAMP_W  = 16;
  localparam int COORD_W = 13;
  localparam int CNT_W   = 10;
  localparam int FAC_W   = 4;
  localparam int SIZE_W  = 11;
  localparam int IDX_W   = 8;
  localparam int DATA_W  = 16;
  localparam int W_W     = 7;
  localparam int ACC_W   = 23;

  localparam logic [IDX_W-1:0] REG_ROWS = 8'd0;
  localparam logic [IDX_W-1:0] REG_COLS = 8'd1;
  localparam logic [IDX_W-1:0] REG_RF   = 8'd2;
  localparam logic [IDX_W-1:0] REG_CF   = 8'd3;

  localparam logic [SIZE_W-1:0] ROW_LIMIT = 11'd1024;
  localparam logic [FAC_W-1:0]  FAC_LIMIT = 4'd8;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic [FAC_W-1:0]  rf;
    logic [FAC_W-1:0]  cf;
  } cfg_t;

  typedef struct packed {
    logic [SAMP_W-1:0] cu;
    logic [SAMP_W-1:0] up;
    logic [SAMP_W-1:0] lt;
    logic [SAMP_W-1:0] ul;
    logic [CNT_W-1:0]  r;
    logic [CNT_W-1:0]  c;
  } job_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    if (v == '0) res = 11'd1;
    else if (v > hi) res = hi;
    else res = v;
    return res;
  endfunction

  function automatic logic [FAC_W-1:0] clamp_fac(logic [FAC_W-1:0] v);
    logic [FAC_W-1:0] res;
    if (v == '0) res = 4'd1;
    else if (v > FAC_LIMIT) res = FAC_LIMIT;
    else res = v;
    return res;
  endfunction

endpackage

// ===== rtl/core/blup_if.sv =====
`timescale 1ns / 1ps
// blup_if: handshake channel interfaces for samples, results and config
// depends on blup_pkg
interface blup_src_if;
  logic                       valid;
  logic                       ready;
  logic [blup_pkg::SAMP_W-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface blup_res_if;
  logic                         valid;
  logic                         ready;
  logic [blup_pkg::SAMP_W-1:0]  value;
  logic [blup_pkg::COORD_W-1:0] out_row;
  logic [blup_pkg::COORD_W-1:0] out_col;
  logic                         last_of_run;
  modport source (output valid, value, out_row, out_col, last_of_run, input ready);
  modport sink (input valid, value, out_row, out_col, last_of_run, output ready);
endinterface

interface blup_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [blup_pkg::IDX_W-1:0]  index;
  logic [blup_pkg::DATA_W-1:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/core/blup_ram.sv =====
`timescale 1ns / 1ps
// blup_ram: generic single-write, single-read ram with registered read
// no dependencies
module blup_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
    if (we_i) mem[waddr_i] <= wdata_i;
  end

endmodule

// ===== rtl/core/blup_queue.sv =====
`timescale 1ns / 1ps
// blup_queue: two-entry job queue between front and back
// depends on blup_pkg
module blup_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  blup_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output blup_pkg::job_t job_o
);

  blup_pkg::job_t ent_q [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = ent_q[rp_q];

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= job_i;
  end

endmodule

// ===== rtl/core/blup_front.sv =====
`timescale 1ns / 1ps
// blup_front: accepts source samples, tracks position, keeps line store and neighbours
// depends on blup_pkg, blup_if, blup_ram
module blup_front #(
  parameter int MAX_COLS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  blup_src_if.sink       src_i,
  input  blup_pkg::cfg_t cfg_i,
  input  logic           restart_i,
  input  logic           full_i,
  output logic           push_o,
  output blup_pkg::job_t job_o
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int SW = (SAMPLE_BITS < blup_pkg::SAMP_W) ? SAMPLE_BITS : blup_pkg::SAMP_W;
  localparam logic [blup_pkg::SAMP_W-1:0] SMASK =
    blup_pkg::SAMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic                          acc_en;
  logic [blup_pkg::SAMP_W-1:0]   cu;
  logic [blup_pkg::CNT_W-1:0]    r_q, r_d, c_q, c_d;
  logic [blup_pkg::SAMP_W-1:0]   left_q, ul_q, up;
  logic                          stg_v_q;
  logic [blup_pkg::SAMP_W-1:0]   stg_cu_q, stg_lt_q;
  logic [blup_pkg::CNT_W-1:0]    stg_r_q, stg_c_q;
  logic [SW-1:0]                 rdata;

  assign push_o    = stg_v_q & ~full_i;
  assign src_i.ready = ~stg_v_q | push_o;
  assign acc_en    = src_i.valid & src_i.ready;
  assign cu        = src_i.sample & SMASK;

  blup_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_line (
    .clk_i   (clk_i),
    .we_i    (acc_en),
    .waddr_i (AW'(c_q)),
    .wdata_i (cu[SW-1:0]),
    .re_i    (acc_en),
    .raddr_i (AW'(c_q)),
    .rdata_o (rdata)
  );

  // upper row is outside the image on source row 0
  assign up = (stg_r_q == '0) ? '0 : blup_pkg::SAMP_W'(rdata);

  always_comb begin
    job_o.cu = stg_cu_q;
    job_o.up = up;
    job_o.lt = stg_lt_q;
    job_o.ul = ul_q;
    job_o.r  = stg_r_q;
    job_o.c  = stg_c_q;
  end

  always_comb begin
    r_d = r_q;
    c_d = c_q;
    if (restart_i) begin
      r_d = '0;
      c_d = '0;
    end else if (acc_en) begin
      if (blup_pkg::SIZE_W'(c_q) + 11'd1 >= cfg_i.cols) begin
        c_d = '0;
        r_d = (blup_pkg::SIZE_W'(r_q) + 11'd1 >= cfg_i.rows) ? '0 : r_q + 10'd1;
      end else begin
        c_d = c_q + 10'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q     <= '0;
      c_q     <= '0;
      left_q  <= '0;
      ul_q    <= '0;
      stg_v_q <= 1'b0;
    end else begin
      r_q <= r_d;
      c_q <= c_d;
      if (acc_en) begin
        left_q  <= cu;
        stg_v_q <= 1'b1;
      end else if (push_o) begin
        stg_v_q <= 1'b0;
      end
      if (push_o) ul_q <= up;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en) begin
      stg_cu_q <= cu;
      stg_lt_q <= left_q;
      stg_r_q  <= r_q;
      stg_c_q  <= c_q;
    end
  end

endmodule

// ===== rtl/core/blup_back.sv =====
`timescale 1ns / 1ps
// blup_back: walks the output points of one job, weights, accumulates and divides
// depends on blup_pkg, blup_if
module blup_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  blup_pkg::cfg_t cfg_i,
  input  blup_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  blup_res_if.source     res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WGT  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                    st_q, st_d;
  logic [blup_pkg::FAC_W-1:0]    a_q, b_q, wa, wb;
  logic [blup_pkg::W_W-1:0]      w_q [4];
  logic [blup_pkg::W_W-1:0]      den_q;
  logic [7:0]                    dv;
  logic [1:0]                    step_q;
  logic [3:0]                    bit_q;
  logic [blup_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [blup_pkg::SAMP_W-1:0]   smp;
  logic [blup_pkg::ACC_W-1:0]    term;
  logic [7:0]                    rem_q;
  logic [8:0]                    trial;
  logic                          ge;
  logic [blup_pkg::SAMP_W-1:0]   xq_q;
  logic [13:0]                   rbase_q, cbase_q;
  logic                          load, last;
  logic                          v_q;

  assign wa    = cfg_i.rf - a_q;
  assign wb    = cfg_i.cf - b_q;
  assign dv    = {den_q, 1'b0};
  assign last  = (a_q == cfg_i.rf) && (b_q == cfg_i.cf);
  assign load  = (st_q == S_OUT) && (~v_q || res_o.ready);
  assign pop_o = load && last;
  assign trial = {rem_q, xq_q[blup_pkg::SAMP_W-1]};
  assign ge    = trial >= {1'b0, dv};
  assign res_o.valid = v_q;

  always_comb begin
    unique case (step_q)
      2'd0:    smp = job_i.ul;
      2'd1:    smp = job_i.up;
      2'd2:    smp = job_i.lt;
      default: smp = job_i.cu;
    endcase
    term  = blup_pkg::ACC_W'(w_q[step_q]) * blup_pkg::ACC_W'(smp);
    acc_d = acc_q + {term[blup_pkg::ACC_W-2:0], 1'b0};
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (!empty_i) st_d = S_WGT;
      S_WGT:  st_d = S_ACC;
      S_ACC:  if (step_q == 2'd3) st_d = S_DIV;
      S_DIV:  if (bit_q == 4'd15) st_d = S_OUT;
      S_OUT: begin
        if (load) st_d = last ? S_IDLE : S_WGT;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      v_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) v_q <= 1'b1;
      else if (res_o.ready) v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        a_q     <= (job_i.r == '0) ? cfg_i.rf : 4'd1;
        b_q     <= (job_i.c == '0) ? cfg_i.cf : 4'd1;
        rbase_q <= 14'(job_i.r - 10'd1) * 14'(cfg_i.rf);
        cbase_q <= 14'(job_i.c - 10'd1) * 14'(cfg_i.cf);
      end
      S_WGT: begin
        w_q[0] <= blup_pkg::W_W'(wa) * blup_pkg::W_W'(wb);
        w_q[1] <= blup_pkg::W_W'(wa) * blup_pkg::W_W'(b_q);
        w_q[2] <= blup_pkg::W_W'(a_q) * blup_pkg::W_W'(wb);
        w_q[3] <= blup_pkg::W_W'(a_q) * blup_pkg::W_W'(b_q);
        den_q  <= blup_pkg::W_W'(cfg_i.rf) * blup_pkg::W_W'(cfg_i.cf);
        acc_q  <= blup_pkg::ACC_W'(blup_pkg::W_W'(cfg_i.rf) * blup_pkg::W_W'(cfg_i.cf));
        step_q <= 2'd0;
      end
      S_ACC: begin
        acc_q  <= acc_d;
        step_q <= step_q + 2'd1;
        rem_q  <= 8'(acc_d[blup_pkg::ACC_W-1:blup_pkg::SAMP_W]);
        xq_q   <= acc_d[blup_pkg::SAMP_W-1:0];
        bit_q  <= 4'd0;
      end
      S_DIV: begin
        rem_q <= ge ? 8'(trial - {1'b0, dv}) : trial[7:0];
        xq_q  <= {xq_q[blup_pkg::SAMP_W-2:0], ge};
        bit_q <= bit_q + 4'd1;
      end
      S_OUT: begin
        if (load && !last) begin
          if (b_q == cfg_i.cf) begin
            a_q <= a_q + 4'd1;
            b_q <= (job_i.c == '0) ? cfg_i.cf : 4'd1;
          end else begin
            b_q <= b_q + 4'd1;
          end
        end
      end
      default: ;
    endcase
    if (load) begin
      res_o.value       <= xq_q;
      res_o.out_row     <= (job_i.r == '0) ? '0 : 13'(rbase_q + 14'(a_q));
      res_o.out_col     <= (job_i.c == '0) ? '0 : 13'(cbase_q + 14'(b_q));
      res_o.last_of_run <= last;
    end
  end

  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i) else $error("pop from empty queue");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (rem_q < dv)) else $error("divider remainder out of range");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT) |-> (a_q <= cfg_i.rf && b_q <= cfg_i.cf && a_q != '0 && b_q != '0))
    else $error("point index out of range");
  a_out_follows_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT && $past(st_q) != S_OUT) |-> $past(st_q) == S_DIV)
    else $error("result without division");

endmodule

// ===== rtl/core/bilinear_upscale_by_factor.sv =====
`timescale 1ns / 1ps
// Bilinear upscaler by integer row and column factors (1..8). Source samples
// arrive in raster order; each yields rf*cf output points (cf, rf or 1 on the
// first row or column), each with its output coordinates and a last flag.
// Each output point passes through a weight step, four multiply-accumulate
// steps, a 16-step radix-2 divider for the rounded quotient and a step that
// loads the output register, and the back end fetches each sample from the
// queue in a further step; the front end takes a new sample every cycle while
// the two-entry queue has room.
// Configuration writes restart the frame and must be made while idle.
// depends on blup_pkg, blup_if, blup_front, blup_queue, blup_back
module bilinear_upscale_by_factor #(
  parameter int MAX_COLS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  blup_src_if.sink   src_i,
  blup_res_if.source res_o,
  blup_cfg_if.sink   cfg_i
);

  localparam logic [blup_pkg::SIZE_W-1:0] COL_HI =
    (MAX_COLS < 1024) ? blup_pkg::SIZE_W'(MAX_COLS) : 11'd1024;

  logic [blup_pkg::SIZE_W-1:0] rows_q, cols_q;
  logic [blup_pkg::FAC_W-1:0]  rf_q, cf_q;
  logic                        wr, hit;
  blup_pkg::cfg_t              cfg;
  logic                        push, full, pop, empty;
  blup_pkg::job_t              job_in, job_out;

  assign cfg_i.ready = 1'b1;
  assign wr  = cfg_i.valid;
  assign hit = wr && (cfg_i.index <= blup_pkg::REG_CF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 11'd1;
      cols_q <= 11'd1;
      rf_q   <= 4'd1;
      cf_q   <= 4'd1;
    end else if (wr) begin
      unique case (cfg_i.index)
        blup_pkg::REG_ROWS: rows_q <= cfg_i.wdata[blup_pkg::SIZE_W-1:0];
        blup_pkg::REG_COLS: cols_q <= cfg_i.wdata[blup_pkg::SIZE_W-1:0];
        blup_pkg::REG_RF:   rf_q   <= cfg_i.wdata[blup_pkg::FAC_W-1:0];
        blup_pkg::REG_CF:   cf_q   <= cfg_i.wdata[blup_pkg::FAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rows = blup_pkg::clamp_size(rows_q, blup_pkg::ROW_LIMIT);
    cfg.cols = blup_pkg::clamp_size(cols_q, COL_HI);
    cfg.rf   = blup_pkg::clamp_fac(rf_q);
    cfg.cf   = blup_pkg::clamp_fac(cf_q);
  end

  blup_front #(.MAX_COLS(MAX_COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .src_i     (src_i),
    .cfg_i     (cfg),
    .restart_i (hit),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_in)
  );

  blup_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  blup_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .job_i   (job_out),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
